// ===== hdl/ndp_pkg.sv =====
`default_nettype none

package ndp_pkg;

  // Fixed field widths
  localparam int unsigned ValueWidth = 14;
  localparam int unsigned DigitWidth = 4;

  // Divide by ten: floor(x / 10) == (x * DivMagic) >> DivShift for x < 81920
  localparam int unsigned Radix      = 10;
  localparam int unsigned MagicWidth = 16;
  localparam int unsigned DivMagic   = 52429;
  localparam int unsigned DivShift   = 19;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [DigitWidth-1:0] digit_t;

  // Per-stage control that travels with the data
  typedef struct packed {
    logic valid;
    logic ok;
  } ctrl_t;

  function automatic int unsigned pow10(input int unsigned e);
    int unsigned p;
    p = 1;
    for (int unsigned k = 0; k < e; k++) begin
      p = p * Radix;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ndp_digit_stage.sv =====
`default_nettype none

// Peel off one decimal digit per stage.
module ndp_digit_stage #(
  parameter int unsigned Count = 4,
  parameter int unsigned Index = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ndp_pkg::ctrl_t        ctrl_i,
  input  wire ndp_pkg::value_t       rest_i,
  input  wire logic [Count-1:0][3:0] digits_i,
  output ndp_pkg::ctrl_t             ctrl_o,
  output ndp_pkg::value_t            rest_o,
  output logic [Count-1:0][3:0]      digits_o
);

  localparam int unsigned ProdW = ndp_pkg::ValueWidth + ndp_pkg::MagicWidth;

  logic [ProdW-1:0]      prod;
  ndp_pkg::value_t       quot;
  ndp_pkg::value_t       tenfold;
  ndp_pkg::value_t       diff;
  ndp_pkg::digit_t       rem;

  ndp_pkg::ctrl_t        ctrl_d, ctrl_q;
  ndp_pkg::value_t       rest_d, rest_q;
  logic [Count-1:0][3:0] digits_d, digits_q;

  always_comb begin
    prod     = ProdW'(rest_i) * ProdW'(ndp_pkg::DivMagic);
    quot     = ndp_pkg::value_t'(prod >> ndp_pkg::DivShift);
    tenfold  = ndp_pkg::value_t'(quot * ndp_pkg::value_t'(ndp_pkg::Radix));
    diff     = rest_i - tenfold;
    rem      = diff[ndp_pkg::DigitWidth-1:0];
    rest_d   = quot;
    digits_d = digits_i;
    digits_d[Index] = rem;
    ctrl_d.valid = ctrl_i.valid;
    // drop the item as soon as a zero digit shows up
    ctrl_d.ok    = ctrl_i.ok && (rem != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    digits_q <= digits_d;
  end

  assign ctrl_o   = ctrl_q;
  assign rest_o   = rest_q;
  assign digits_o = digits_q;

endmodule

`default_nettype wire

// ===== hdl/ndp_permute.sv =====
`default_nettype none

// Two stages: locate pivot and swap partner, then swap and reverse the tail.
module ndp_permute #(
  parameter int unsigned Count = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ndp_pkg::ctrl_t        ctrl_i,
  input  wire ndp_pkg::value_t       rest_i,
  input  wire logic [Count-1:0][3:0] digits_i,
  output ndp_pkg::ctrl_t             ctrl_o,
  output logic [Count-1:0][3:0]      digits_o
);

  localparam int unsigned IdxW = $clog2(Count);

  // Stage A
  logic                  piv_hit;
  logic                  best_hit;
  logic [IdxW-1:0]       piv;
  logic [IdxW-1:0]       best;
  ndp_pkg::digit_t       piv_digit;

  ndp_pkg::ctrl_t        a_ctrl_d, a_ctrl_q;
  logic [IdxW-1:0]       a_piv_d, a_piv_q;
  logic [IdxW-1:0]       a_best_d, a_best_q;
  logic [Count-1:0][3:0] a_digits_q;

  always_comb begin
    piv_hit = 1'b0;
    piv     = '0;
    for (int k = 1; k < Count; k++) begin
      if (!piv_hit && (digits_i[k] < digits_i[k-1])) begin
        piv_hit = 1'b1;
        piv     = IdxW'(k);
      end
    end
    piv_digit = digits_i[piv];
    // the tail is ascending toward the pivot, so the first larger digit is the smallest
    best_hit = 1'b0;
    best     = '0;
    for (int k = 0; k < Count; k++) begin
      if (!best_hit && (k < int'(piv)) && (digits_i[k] > piv_digit)) begin
        best_hit = 1'b1;
        best     = IdxW'(k);
      end
    end
    a_ctrl_d.valid = ctrl_i.valid;
    a_ctrl_d.ok    = ctrl_i.ok && (rest_i == '0) && piv_hit && best_hit;
    a_piv_d        = piv;
    a_best_d       = best;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q <= '0;
    end else begin
      a_ctrl_q <= a_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_piv_q    <= a_piv_d;
    a_best_q   <= a_best_d;
    a_digits_q <= digits_i;
  end

  // Stage B
  logic [Count-1:0][3:0] swapped;
  logic [IdxW-1:0]       src;
  ndp_pkg::ctrl_t        b_ctrl_q;
  logic [Count-1:0][3:0] b_digits_d, b_digits_q;

  always_comb begin
    swapped           = a_digits_q;
    swapped[a_piv_q]  = a_digits_q[a_best_q];
    swapped[a_best_q] = a_digits_q[a_piv_q];
    b_digits_d        = swapped;
    src               = '0;
    // reverse the tail so its largest digit lands in the lowest place
    for (int k = 0; k < Count; k++) begin
      if (k < int'(a_piv_q)) begin
        src           = IdxW'(int'(a_piv_q) - 1 - k);
        b_digits_d[k] = swapped[src];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctrl_q <= '0;
    end else begin
      b_ctrl_q <= a_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_digits_q <= b_digits_d;
  end

  assign ctrl_o   = b_ctrl_q;
  assign digits_o = b_digits_q;

endmodule

`default_nettype wire

// ===== hdl/ndp_pack.sv =====
`default_nettype none

// Fold the digits back into a binary value and register the result.
module ndp_pack #(
  parameter int unsigned Count = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ndp_pkg::ctrl_t        ctrl_i,
  input  wire logic [Count-1:0][3:0] digits_i,
  output logic                       done_o,
  output ndp_pkg::value_t            next_value_o,
  output logic                       found_o
);

  localparam int unsigned SumW = (ndp_pkg::DigitWidth * Count > ndp_pkg::ValueWidth) ?
                                 ndp_pkg::DigitWidth * Count : ndp_pkg::ValueWidth;

  logic [SumW-1:0] sum;
  ndp_pkg::value_t value_d, value_q;
  logic            done_q;
  logic            found_q;

  always_comb begin
    sum = '0;
    for (int unsigned k = 0; k < Count; k++) begin
      sum = sum + SumW'(digits_i[k]) * SumW'(ndp_pkg::pow10(k));
    end
    value_d = ctrl_i.ok ? sum[ndp_pkg::ValueWidth-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      done_q  <= ctrl_i.valid;
      found_q <= ctrl_i.valid && ctrl_i.ok;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign next_value_o = value_q;

endmodule

`default_nettype wire

// ===== hdl/next_digit_permutation_unit.sv =====
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// command  | start_i, busy_o    | current_value_i[13:0]
// result   | done_o (strobe)    | next_value_o[13:0], found_o
//
// A word is taken at every rising edge where start_i is high and busy_o is
// low; busy_o stays low, so a new word may enter on every cycle.
// Each word passes through one register stage per decimal digit, two for pivot
// search and swap/reverse, and one to repack.
// done_o marks each result for exactly one cycle; the receiver cannot stall.
// Reset clears only the control flags (valid, ok, done_o, found_o); data is not reset.
module next_digit_permutation_unit #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire ndp_pkg::value_t current_value_i,
  output logic                 done_o,
  output ndp_pkg::value_t      next_value_o,
  output logic                 found_o
);

  // Stage boundaries of the digit extraction chain
  ndp_pkg::ctrl_t              ctrl_s   [DIGIT_COUNT+1];
  ndp_pkg::value_t             rest_s   [DIGIT_COUNT+1];
  logic [DIGIT_COUNT-1:0][3:0] digits_s [DIGIT_COUNT+1];

  ndp_pkg::ctrl_t              perm_ctrl;
  logic [DIGIT_COUNT-1:0][3:0] perm_digits;

  // Pure pipeline with no backpressure: never hold off the sender
  assign busy_o = 1'b0;

  // Start every word as acceptable; stages drop it on a zero digit
  assign ctrl_s[0].valid = start_i && !busy_o;
  assign ctrl_s[0].ok    = 1'b1;
  assign rest_s[0]       = current_value_i;
  assign digits_s[0]     = '0;

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
    ndp_digit_stage #(
      .Count (DIGIT_COUNT),
      .Index (g)
    ) u_digit (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_s[g]),
      .rest_i   (rest_s[g]),
      .digits_i (digits_s[g]),
      .ctrl_o   (ctrl_s[g+1]),
      .rest_o   (rest_s[g+1]),
      .digits_o (digits_s[g+1])
    );
  end

  // Leftover quotient flags a value with too many digits
  ndp_permute #(
    .Count (DIGIT_COUNT)
  ) u_permute (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_s[DIGIT_COUNT]),
    .rest_i   (rest_s[DIGIT_COUNT]),
    .digits_i (digits_s[DIGIT_COUNT]),
    .ctrl_o   (perm_ctrl),
    .digits_o (perm_digits)
  );

  // Repack to binary; zero the value when there is no successor
  ndp_pack #(
    .Count (DIGIT_COUNT)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (perm_ctrl),
    .digits_i     (perm_digits),
    .done_o       (done_o),
    .next_value_o (next_value_o),
    .found_o      (found_o)
  );

endmodule

`default_nettype wire

// ===== hdl/ndp_checker.sv =====
`default_nettype none

module ndp_checker #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start_i,
  input wire logic            busy_o,
  input wire ndp_pkg::value_t current_value_i,
  input wire logic            done_o,
  input wire ndp_pkg::value_t next_value_o,
  input wire logic            found_o
);

  localparam int unsigned Latency = DIGIT_COUNT + 3;

  // Every accepted word yields a strobe once it has passed the whole pipeline
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result strobe missing after accepted word");

  a_found_strobed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> done_o)
    else $error("found without result strobe");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (next_value_o == '0))
    else $error("nonzero value with no successor");

  // A successor is strictly larger than the word it came from
  a_larger : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (next_value_o > $past(current_value_i, Latency)))
    else $error("successor not larger than input");

endmodule

bind next_digit_permutation_unit ndp_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_ndp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .current_value_i (current_value_i),
  .done_o          (done_o),
  .next_value_o    (next_value_o),
  .found_o         (found_o)
);

`default_nettype wire
